[rtl/lfc_pkg.sv]
// ----------------------------------------------------------------------------
// lfc_pkg
// Shared types and constants of the lagged Fibonacci memory pattern checker.
// ----------------------------------------------------------------------------
`default_nettype none

package lfc_pkg;

    // Generator shape: long lag (table depth) and short lag.
    localparam int LONG_LAG   = 7;
    localparam int SHORT_LAG  = 3;
    // Position of the short-lag tap in the rotating table, counted from the head.
    localparam int TAP_OFS    = (LONG_LAG - (SHORT_LAG % LONG_LAG)) % LONG_LAG;
    // Rotations that line the freshly seeded table up with the starting tap.
    localparam int ROT_STEPS  = SHORT_LAG % LONG_LAG;
    localparam int WARM_STEPS = 10 * LONG_LAG;
    localparam int CNT_W      = $clog2(WARM_STEPS);

    localparam logic [31:0] LCG_MUL = 32'd1103515245;
    localparam logic [31:0] LCG_INC = 32'd12345;

    localparam logic [31:0] MASK_BYTE = 32'h0000_00ff;
    localparam logic [31:0] MASK_HALF = 32'h0000_ffff;
    localparam logic [31:0] MASK_WORD = 32'hffff_ffff;

    // Configuration port
    localparam int ADDR_W    = 4;
    localparam int REG_IDX_W = ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_SEED   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_REGION = 2'd2;

    // Element width codes
    localparam logic [1:0] WM_BYTE = 2'd0;
    localparam logic [1:0] WM_HALF = 2'd1;
    localparam logic [1:0] WM_WORD = 2'd2;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_FILL  = 2'd1,
        CMD_CHECK = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_MISMATCH = 2'd1,
        ST_INACTIVE = 2'd2
    } status_t;

    typedef struct packed {
        logic [31:0] seed;
        logic [1:0]  width_mode;
        logic [31:0] region_bytes;
    } cfg_t;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_LOAD,
        OP_MUL,
        OP_LCG,
        OP_ROT,
        OP_STEP
    } lag_op_t;

    typedef struct packed {
        lag_op_t     op;
        logic [31:0] seed;
    } lag_ctl_t;

    function automatic logic [31:0] width_mask(input logic [1:0] wm);
        logic [31:0] m;
        case (wm)
            WM_BYTE: m = MASK_BYTE;
            WM_HALF: m = MASK_HALF;
            default: m = MASK_WORD;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

[rtl/lfc_cmd_if.sv]
// ----------------------------------------------------------------------------
// lfc_cmd_if
// Command channel: command code and read-back data, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface lfc_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [31:0] observed;

    modport source (output valid, output command, output observed, input ready);
    modport sink   (input valid, input command, input observed, output ready);
endinterface

`default_nettype wire

[rtl/lfc_rsp_if.sv]
// ----------------------------------------------------------------------------
// lfc_rsp_if
// Response channel: status and pattern report, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface lfc_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] expected;
    logic [31:0] observed_echo;
    logic [31:0] remaining;
    logic        last;

    modport source (output valid, output status, output expected, output observed_echo,
                    output remaining, output last, input ready);
    modport sink   (input valid, input status, input expected, input observed_echo,
                    input remaining, input last, output ready);
endinterface

`default_nettype wire

[rtl/lfc_apb_regs.sv]
// ----------------------------------------------------------------------------
// lfc_apb_regs
// APB-style register file: seed, element width and region size.
// ----------------------------------------------------------------------------
`default_nettype none

module lfc_apb_regs (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [lfc_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic      [31:0]                prdata,
    output logic                            pready,
    output lfc_pkg::cfg_t                   cfg
);

    logic [31:0] seed_reg, seed_next;
    logic [1:0]  width_reg, width_next;
    logic [31:0] region_reg, region_next;
    logic [lfc_pkg::REG_IDX_W-1:0] idx;
    logic        wr_en;

    assign idx    = paddr[lfc_pkg::ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb
    begin
        seed_next   = seed_reg;
        width_next  = width_reg;
        region_next = region_reg;
        if (wr_en)
        begin
            unique case (idx)
                lfc_pkg::REG_SEED:   seed_next   = pwdata;
                lfc_pkg::REG_WIDTH:  width_next  = pwdata[1:0];
                lfc_pkg::REG_REGION: region_next = pwdata;
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            lfc_pkg::REG_SEED:   prdata = seed_reg;
            lfc_pkg::REG_WIDTH:  prdata = {30'd0, width_reg};
            lfc_pkg::REG_REGION: prdata = region_reg;
            default:             prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg   <= 32'd0;
            width_reg  <= lfc_pkg::WM_WORD;
            region_reg <= 32'd0;
        end
        else
        begin
            seed_reg   <= seed_next;
            width_reg  <= width_next;
            region_reg <= region_next;
        end
    end

    assign cfg.seed         = seed_reg;
    assign cfg.width_mode   = width_reg;
    assign cfg.region_bytes = region_reg;

endmodule

`default_nettype wire

[rtl/lfc_lag_unit.sv]
// ----------------------------------------------------------------------------
// lfc_lag_unit
// Rotating lag table with one shared adder and one multiplier stage.
// ----------------------------------------------------------------------------
`default_nettype none

module lfc_lag_unit (
    input  wire logic              clk,
    input  wire lfc_pkg::lag_ctl_t ctl,
    output logic [31:0]            sum
);

    // Head of the table is the slot under the tap; the short-lag partner
    // sits at a fixed offset, so every step is a shift with one add.
    logic [31:0] t_reg [lfc_pkg::LONG_LAG];
    logic [31:0] t_next [lfc_pkg::LONG_LAG];
    logic [31:0] prod_reg, prod_next;
    logic [31:0] add_a, add_b;
    logic [31:0] fill;
    logic        shift_en;

    always_comb
    begin
        if (ctl.op == lfc_pkg::OP_LCG)
        begin
            add_a = prod_reg;
            add_b = lfc_pkg::LCG_INC;
        end
        else
        begin
            add_a = t_reg[0];
            add_b = t_reg[lfc_pkg::TAP_OFS];
        end
    end

    assign sum = add_a + add_b;

    always_comb
    begin
        prod_next = prod_reg;
        fill      = sum;
        shift_en  = 1'b0;
        unique case (ctl.op)
            lfc_pkg::OP_HOLD: ;
            lfc_pkg::OP_LOAD:
            begin
                fill     = ctl.seed;
                shift_en = 1'b1;
            end
            lfc_pkg::OP_MUL:  prod_next = t_reg[lfc_pkg::LONG_LAG-1] * lfc_pkg::LCG_MUL;
            lfc_pkg::OP_LCG:  shift_en = 1'b1;
            lfc_pkg::OP_ROT:
            begin
                fill     = t_reg[0];
                shift_en = 1'b1;
            end
            lfc_pkg::OP_STEP: shift_en = 1'b1;
            default: ;
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < lfc_pkg::LONG_LAG; i++)
        begin
            t_next[i] = t_reg[i];
        end
        if (shift_en)
        begin
            for (int i = 0; i < lfc_pkg::LONG_LAG - 1; i++)
            begin
                t_next[i] = t_reg[i+1];
            end
            t_next[lfc_pkg::LONG_LAG-1] = fill;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < lfc_pkg::LONG_LAG; i++)
        begin
            t_reg[i] <= t_next[i];
        end
        prod_reg <= prod_next;
    end

endmodule

`default_nettype wire

[rtl/lagged_fibonacci_memory_pattern_checker.sv]
// Fill and check: one transaction per cycle while idle and the output stage is free;
//   the response is registered at the accepting edge and is offered in the next cycle.
// Start: seeding through the shared adder/multiplier, tap alignment, then
//   warm-up steps.
// Reset: control state cleared, engine inactive; lag table is undefined until a start.
// ----------------------------------------------------------------------------
// lagged_fibonacci_memory_pattern_checker
// Additive lagged Fibonacci pattern engine for memory test: seeds from an LCG,
// warms up, then produces fill values and checks read-back data.
// ----------------------------------------------------------------------------
`default_nettype none

module lagged_fibonacci_memory_pattern_checker (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [lfc_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic      [31:0]                prdata,
    output logic                            pready,
    lfc_cmd_if.sink                         cmd,
    lfc_rsp_if.source                       rsp
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_MUL,
        S_LCG,
        S_ROT,
        S_WARM
    } state_t;

    lfc_pkg::cfg_t     cfg;
    lfc_pkg::lag_ctl_t ctl;
    logic [31:0]       sum;

    state_t                    state_reg, state_next;
    logic [lfc_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                      running_reg, running_next;
    logic [31:0]               left_reg, left_next;

    // Response register (one deep output stage)
    logic                      rsp_valid_reg, rsp_valid_next;
    lfc_pkg::status_t          status_reg, status_next;
    logic [31:0]               expected_reg, expected_next;
    logic [31:0]               echo_reg, echo_next;
    logic [31:0]               remaining_reg, remaining_next;
    logic                      last_reg, last_next;

    logic                      accept;
    logic                      rsp_free;
    logic [31:0]               mask;
    logic [31:0]               value;
    logic [31:0]               obs_masked;
    logic [31:0]               elem_count;

    lfc_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lfc_lag_unit u_lag (
        .clk (clk),
        .ctl (ctl),
        .sum (sum)
    );

    // The output stage frees up in the same cycle it is drained.
    assign rsp_free  = !rsp_valid_reg || rsp.ready;
    assign cmd.ready = (state_reg == S_IDLE) && rsp_free;
    assign accept    = cmd.valid && cmd.ready;

    // Mask follows the live width register; the element count is taken when warm-up completes.
    assign mask       = lfc_pkg::width_mask(cfg.width_mode);
    assign value      = sum & mask;
    assign obs_masked = cmd.observed & mask;

    always_comb
    begin
        case (cfg.width_mode)
            lfc_pkg::WM_BYTE: elem_count = cfg.region_bytes;
            lfc_pkg::WM_HALF: elem_count = {1'b0, cfg.region_bytes[31:1]};
            default:          elem_count = {2'b00, cfg.region_bytes[31:2]};
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        running_next   = running_reg;
        left_next      = left_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        status_next    = status_reg;
        expected_next  = expected_reg;
        echo_next      = echo_reg;
        remaining_next = remaining_reg;
        last_next      = last_reg;
        ctl.op         = lfc_pkg::OP_HOLD;
        ctl.seed       = cfg.seed;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    // Default answer: inactive, all fields zero, no state change.
                    rsp_valid_next = 1'b1;
                    status_next    = lfc_pkg::ST_INACTIVE;
                    expected_next  = 32'd0;
                    echo_next      = 32'd0;
                    remaining_next = 32'd0;
                    last_next      = 1'b0;
                    case (cmd.command)
                        lfc_pkg::CMD_START:
                        begin
                            // Hold the response until warm-up completes.
                            rsp_valid_next = 1'b0;
                            state_next     = S_LOAD;
                        end
                        lfc_pkg::CMD_FILL, lfc_pkg::CMD_CHECK:
                        begin
                            if (running_reg && (left_reg != 32'd0))
                            begin
                                ctl.op         = lfc_pkg::OP_STEP;
                                expected_next  = value;
                                remaining_next = left_reg;
                                last_next      = (left_reg == 32'd1);
                                status_next    = lfc_pkg::ST_OK;
                                if (cmd.command == lfc_pkg::CMD_CHECK)
                                begin
                                    echo_next = obs_masked;
                                end
                                if ((cmd.command == lfc_pkg::CMD_CHECK)
                                    && (obs_masked != value))
                                begin
                                    // Stop the engine; the count stays put.
                                    status_next  = lfc_pkg::ST_MISMATCH;
                                    running_next = 1'b0;
                                end
                                else
                                begin
                                    left_next = left_reg - 32'd1;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_LOAD:
            begin
                // The tail slot (LONG_LAG-1) takes the seed.
                ctl.op     = lfc_pkg::OP_LOAD;
                cnt_next   = lfc_pkg::CNT_W'(1);
                state_next = S_MUL;
            end
            S_MUL:
            begin
                ctl.op     = lfc_pkg::OP_MUL;
                state_next = S_LCG;
            end
            S_LCG:
            begin
                ctl.op = lfc_pkg::OP_LCG;
                if (cnt_reg == lfc_pkg::CNT_W'(lfc_pkg::LONG_LAG - 1))
                begin
                    cnt_next = '0;
                    if (lfc_pkg::ROT_STEPS == 0)
                    begin
                        state_next = S_WARM;
                    end
                    else
                    begin
                        state_next = S_ROT;
                    end
                end
                else
                begin
                    cnt_next   = cnt_reg + lfc_pkg::CNT_W'(1);
                    state_next = S_MUL;
                end
            end
            S_ROT:
            begin
                // Rotate so the tap slot sits at the head of the table.
                ctl.op = lfc_pkg::OP_ROT;
                if (cnt_reg == lfc_pkg::CNT_W'(lfc_pkg::ROT_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_WARM;
                end
                else
                begin
                    cnt_next = cnt_reg + lfc_pkg::CNT_W'(1);
                end
            end
            S_WARM:
            begin
                ctl.op = lfc_pkg::OP_STEP;
                if (cnt_reg == lfc_pkg::CNT_W'(lfc_pkg::WARM_STEPS - 1))
                begin
                    cnt_next       = '0;
                    state_next     = S_IDLE;
                    running_next   = 1'b1;
                    left_next      = elem_count;
                    rsp_valid_next = 1'b1;
                    status_next    = lfc_pkg::ST_OK;
                    expected_next  = 32'd0;
                    echo_next      = 32'd0;
                    remaining_next = elem_count;
                    last_next      = 1'b0;
                end
                else
                begin
                    cnt_next = cnt_reg + lfc_pkg::CNT_W'(1);
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            running_reg   <= 1'b0;
            left_reg      <= 32'd0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            running_reg   <= running_next;
            left_reg      <= left_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Response payload: no reset needed.
    always_ff @(posedge clk)
    begin
        status_reg    <= status_next;
        expected_reg  <= expected_next;
        echo_reg      <= echo_next;
        remaining_reg <= remaining_next;
        last_reg      <= last_next;
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.status        = status_reg;
    assign rsp.expected      = expected_reg;
    assign rsp.observed_echo = echo_reg;
    assign rsp.remaining     = remaining_reg;
    assign rsp.last          = last_reg;

`ifndef ASSERT_OFF
    // No response may be pending while a start sequence runs.
    a_busy_no_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !rsp_valid_reg)
        else $error("response pending during start sequence");

    // A fill on a live region consumes exactly one element.
    a_fill_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (cmd.command == lfc_pkg::CMD_FILL) && running_reg && (left_reg != 32'd0))
        |=> (left_reg == $past(left_reg) - 32'd1))
        else $error("element count did not advance on fill");

    // A pending mismatch report means the engine has stopped.
    a_mismatch_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && (status_reg == lfc_pkg::ST_MISMATCH)) |-> !running_reg)
        else $error("engine still running after mismatch");

    // Completing a start always leaves the engine running.
    a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_WARM) && (state_next == S_IDLE)) |=> (running_reg && rsp_valid_reg))
        else $error("start did not arm the engine");
`endif

endmodule

`default_nettype wire
